FILE: rtl/assert_macros.svh
// Assertion shorthands for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/fet_pkg.sv
`default_nettype none

package fet_pkg;

    localparam int TABLE_BYTES = 16384;

    localparam int CMD_W   = 2;
    localparam int INDEX_W = 14;
    localparam int VALUE_W = 32;
    localparam int TYPE_W  = 2;
    localparam int OFF_W   = INDEX_W + 2;
    localparam int LANE_W  = 2;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_FAT_TYPE = 1'b0;

    localparam logic [TYPE_W-1:0] FAT12 = 2'd0;
    localparam logic [TYPE_W-1:0] FAT16 = 2'd1;

    localparam logic [15:0] FAT12_ODD_KEEP  = 16'h000f;
    localparam logic [15:0] FAT12_EVEN_KEEP = 16'hf000;
    localparam logic [15:0] FAT12_MASK      = 16'h0fff;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_LOAD  = 2'd2,
        CMD_DUMP  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_RWAIT,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              load_in;
        logic              rd_issue;
        logic              wr_en;
        logic [LANE_W-1:0] lane;
        logic              out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_t              in_cmd;
        logic              in_oob;
        cmd_t              cmd;
        logic              fat12;
        logic [LANE_W-1:0] last_lane;
        logic              out_free;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/fet_ctrl.sv
`default_nettype none

module fet_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire fet_pkg::dp_status_t status,
    output fet_pkg::ctrl_cmd_t      ctrl
);

    fet_pkg::state_t                  state_reg, state_next;
    logic [fet_pkg::LANE_W-1:0]       cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fet_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        s_ready       = 1'b0;
        ctrl.load_in  = 1'b0;
        ctrl.rd_issue = 1'b0;
        ctrl.wr_en    = 1'b0;
        ctrl.lane     = cnt_reg;
        ctrl.out_load = 1'b0;
        unique case (state_reg)
            fet_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cnt_next = '0;
                if (s_valid) begin
                    ctrl.load_in = 1'b1;
                    if (status.in_oob) begin
                        state_next = fet_pkg::ST_DONE;
                    end else begin
                        unique case (status.in_cmd)
                            fet_pkg::CMD_READ,
                            fet_pkg::CMD_DUMP:  state_next = fet_pkg::ST_READ;
                            fet_pkg::CMD_LOAD:  state_next = fet_pkg::ST_WRITE;
                            fet_pkg::CMD_WRITE: state_next = status.fat12 ?
                                fet_pkg::ST_READ : fet_pkg::ST_WRITE;
                            default:            state_next = fet_pkg::ST_DONE;
                        endcase
                    end
                end
            end
            fet_pkg::ST_READ: begin
                ctrl.rd_issue = 1'b1;
                if (cnt_reg == status.last_lane) begin
                    cnt_next   = '0;
                    state_next = fet_pkg::ST_RWAIT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            fet_pkg::ST_RWAIT: begin
                state_next = (status.cmd == fet_pkg::CMD_WRITE) ?
                    fet_pkg::ST_WRITE : fet_pkg::ST_DONE;
            end
            fet_pkg::ST_WRITE: begin
                ctrl.wr_en = 1'b1;
                if (cnt_reg == status.last_lane) begin
                    cnt_next   = '0;
                    state_next = fet_pkg::ST_DONE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            fet_pkg::ST_DONE: begin
                if (status.out_free) begin
                    ctrl.out_load = 1'b1;
                    state_next    = fet_pkg::ST_IDLE;
                end
            end
            default: state_next = fet_pkg::ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/fet_dpath.sv
`default_nettype none

module fet_dpath #(
    parameter int TABLE_BYTES = fet_pkg::TABLE_BYTES
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [fet_pkg::TYPE_W-1:0]    fat_type,
    input  wire logic [fet_pkg::CMD_W-1:0]     s_cmd,
    input  wire logic [fet_pkg::INDEX_W-1:0]   s_index,
    input  wire logic [fet_pkg::VALUE_W-1:0]   s_value,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [fet_pkg::VALUE_W-1:0]        m_read_value,
    output logic                               m_status,
    output logic                               m_dirty,
    input  wire fet_pkg::ctrl_cmd_t            ctrl,
    output fet_pkg::dp_status_t                status
);

    localparam int AW    = (TABLE_BYTES > 1) ? $clog2(TABLE_BYTES) : 1;
    localparam int OFF_W = fet_pkg::OFF_W;
    localparam int LW    = fet_pkg::LANE_W;

    logic [7:0] mem [TABLE_BYTES];

    fet_pkg::cmd_t                 cmd_reg;
    logic [fet_pkg::VALUE_W-1:0]   val_reg;
    logic                          odd_reg;
    logic [OFF_W-1:0]              off_reg;
    logic [LW-1:0]                 last_reg;
    logic                          oob_reg;
    logic [fet_pkg::VALUE_W-1:0]   word_reg;
    logic [7:0]                    rdata_reg;
    logic                          cap_reg;
    logic [LW-1:0]                 lane_d_reg;
    logic                          dirty_reg, dirty_next;
    logic                          m_valid_reg;
    logic [fet_pkg::VALUE_W-1:0]   m_read_value_reg, m_read_value_next;
    logic                          m_status_reg;
    logic                          m_dirty_reg;

    fet_pkg::cmd_t                 in_cmd;
    logic                          fat12, fat16;
    logic [15:0]                   idx3;
    logic [OFF_W-1:0]              off_in;
    logic [LW-1:0]                 last_in;
    logic [OFF_W:0]                end_in;
    logic                          oob_in;
    logic [OFF_W:0]                byte_addr;
    logic [AW-1:0]                 mem_addr;
    logic [fet_pkg::VALUE_W-1:0]   new_word;
    logic [7:0]                    wbyte;

    assign in_cmd = fet_pkg::cmd_t'(s_cmd);
    assign fat12  = (fat_type == fet_pkg::FAT12);
    assign fat16  = (fat_type == fet_pkg::FAT16);
    assign idx3   = {1'b0, s_index, 1'b0} + {2'b00, s_index};

    always_comb begin
        if (s_cmd[1]) begin
            off_in  = {2'b00, s_index};
            last_in = 2'd0;
        end else if (fat12) begin
            off_in  = {1'b0, idx3[15:1]};
            last_in = 2'd1;
        end else if (fat16) begin
            off_in  = {1'b0, s_index, 1'b0};
            last_in = 2'd1;
        end else begin
            off_in  = {s_index, 2'b00};
            last_in = 2'd3;
        end
        end_in = {1'b0, off_in} + (OFF_W + 1)'(last_in) + 1'b1;
        oob_in = 32'(end_in) > 32'(TABLE_BYTES);
    end

    assign byte_addr = {1'b0, off_reg} + (OFF_W + 1)'(ctrl.lane);
    assign mem_addr  = AW'(byte_addr);

    always_comb begin
        logic [15:0] w16;
        w16 = word_reg[15:0];
        if (fat12) begin
            if (odd_reg) begin
                new_word = {16'h0000, (w16 & fet_pkg::FAT12_ODD_KEEP) | {val_reg[11:0], 4'h0}};
            end else begin
                new_word = {16'h0000, (w16 & fet_pkg::FAT12_EVEN_KEEP) | {4'h0, val_reg[11:0]}};
            end
        end else begin
            new_word = val_reg;
        end
        wbyte = (cmd_reg == fet_pkg::CMD_LOAD) ? val_reg[7:0] : new_word[{ctrl.lane, 3'b000} +: 8];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[mem_addr] <= wbyte;
        end
        if (ctrl.rd_issue) begin
            rdata_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_in) begin
            cmd_reg  <= in_cmd;
            val_reg  <= s_value;
            odd_reg  <= s_index[0];
            off_reg  <= off_in;
            last_reg <= last_in;
            oob_reg  <= oob_in;
        end
        lane_d_reg <= ctrl.lane;
        if (cap_reg) begin
            word_reg[{lane_d_reg, 3'b000} +: 8] <= rdata_reg;
        end
    end

    always_comb begin
        dirty_next = dirty_reg | (!oob_reg && cmd_reg == fet_pkg::CMD_WRITE);
        m_read_value_next = '0;
        if (!oob_reg) begin
            unique case (cmd_reg)
                fet_pkg::CMD_READ: begin
                    if (fat12) begin
                        m_read_value_next = odd_reg ? {20'h0, word_reg[15:4]}
                                                    : {20'h0, word_reg[11:0]};
                    end else if (fat16) begin
                        m_read_value_next = {16'h0000, word_reg[15:0]};
                    end else begin
                        m_read_value_next = word_reg;
                    end
                end
                fet_pkg::CMD_DUMP: m_read_value_next = {24'h0, word_reg[7:0]};
                fet_pkg::CMD_WRITE,
                fet_pkg::CMD_LOAD: m_read_value_next = '0;
                default:           m_read_value_next = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= 1'b0;
            dirty_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            m_dirty_reg <= 1'b0;
        end else begin
            cap_reg <= ctrl.rd_issue;
            if (ctrl.out_load) begin
                dirty_reg   <= dirty_next;
                m_valid_reg <= 1'b1;
                m_dirty_reg <= dirty_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            m_read_value_reg <= m_read_value_next;
            m_status_reg     <= oob_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = m_read_value_reg;
    assign m_status     = m_status_reg;
    assign m_dirty      = m_dirty_reg;

    assign status.in_cmd    = in_cmd;
    assign status.in_oob    = oob_in;
    assign status.cmd       = cmd_reg;
    assign status.fat12     = fat12;
    assign status.last_lane = last_reg;
    assign status.out_free  = !m_valid_reg || m_ready;

endmodule

`default_nettype wire

FILE: rtl/fat_entry_table_access_top.sv
// File allocation table entry access over a byte-wide table memory.
// Input channel s_*: cmd (read entry, write entry, load byte, dump byte),
// index (entry number, or byte address for load and dump) and value.
// Result channel m_*: one transfer per input, carrying read_value, status
// (set when the access runs past the table) and the sticky dirty flag.
// fat_type (FAT12, FAT16, FAT32) is written over the APB port at address 0
// while no command is in flight.
// One command is processed at a time; the single-port table memory moves
// one byte per cycle. A read or dump fetches its bytes; a FAT12 write first
// reads the entry to keep the neighbouring entry's bits; other writes and
// byte loads store directly; an out-of-range command skips the table.
// A finished result sits in the output register while the next command is
// taken; when the receiver stalls, a second finished result waits in the
// engine and no further command is accepted until the first is taken.
// Reset clears the control state, the dirty flag and fat_type; the table
// memory holds no reset value and must be loaded before it is read.
`default_nettype none

module fat_entry_table_access_top #(
    parameter int TABLE_BYTES = fet_pkg::TABLE_BYTES
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [fet_pkg::CMD_W-1:0]         s_cmd,
    input  wire logic [fet_pkg::INDEX_W-1:0]       s_index,
    input  wire logic [fet_pkg::VALUE_W-1:0]       s_value,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [fet_pkg::VALUE_W-1:0]            m_read_value,
    output logic                                   m_status,
    output logic                                   m_dirty,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [fet_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [fet_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [fet_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                   pready
);

    logic [fet_pkg::TYPE_W-1:0] fat_type_reg;
    logic                       reg_hit;
    fet_pkg::ctrl_cmd_t         ctrl;
    fet_pkg::dp_status_t        status;

    assign reg_hit = (paddr[fet_pkg::APB_ADDR_W-1:2] == fet_pkg::REG_FAT_TYPE);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? {{(fet_pkg::APB_DATA_W - fet_pkg::TYPE_W){1'b0}}, fat_type_reg}
                             : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fat_type_reg <= fet_pkg::FAT12;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            fat_type_reg <= pwdata[fet_pkg::TYPE_W-1:0];
        end
    end

    fet_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .ctrl    (ctrl)
    );

    fet_dpath #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fat_type     (fat_type_reg),
        .s_cmd        (s_cmd),
        .s_index      (s_index),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_status     (m_status),
        .m_dirty      (m_dirty),
        .ctrl         (ctrl),
        .status       (status)
    );

endmodule

`default_nettype wire

FILE: rtl/fet_checker.sv
`default_nettype none
`include "assert_macros.svh"

module fet_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_valid,
    input wire logic                           s_ready,
    input wire logic                           m_valid,
    input wire logic                           m_ready,
    input wire logic [fet_pkg::VALUE_W-1:0]    m_read_value,
    input wire logic                           m_status,
    input wire logic                           m_dirty
);

    `ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready, "second transfer taken while busy")
    `ASSERT_IMPL(a_oob_zero, aclk, aresetn, m_valid && m_status, m_read_value == '0, "out-of-range result carries data")
    `ASSERT_NEXT(a_dirty_sticky, aclk, aresetn, m_dirty, m_dirty, "dirty flag cleared")
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_read_value), "stalled result changed")

endmodule

bind fat_entry_table_access_top fet_checker u_fet_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_read_value (m_read_value),
    .m_status     (m_status),
    .m_dirty      (m_dirty)
);

`default_nettype wire
